[design/lgr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgr_pkg - shared types and constants of the Lee grid maze router
// Grid geometry, command and status codes, sequencer states, neighbour step functions.
// ----------------------------------------------------------------------------
package lgr_pkg;

	localparam int COORD_W     = 5;
	localparam int GRID_WIDTH  = 32;
	localparam int GRID_HEIGHT = 32;
	localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
	localparam int CELL_AW     = 2 * COORD_W;
	localparam int MAX_LEN     = 1023;
	localparam int LEN_W       = 10;
	localparam int WAVE_W      = 11;
	localparam logic [WAVE_W-1:0] UNNUMBERED = '1;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_ROUTE  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_WALL   = 2'd1;
	localparam logic [1:0] STS_NOPATH = 2'd2;
	localparam logic [1:0] STS_IDXBAD = 2'd3;

	// neighbour order: +x, +y, -x, -y
	localparam logic [1:0] DIR_LAST = 2'd3;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_WCELL,
		ST_R_OPS, ST_R_OPG, ST_R_OPV, ST_R_INIT, ST_R_SEED,
		ST_W_RD, ST_W_CHK, ST_N_RD, ST_N_CHK, ST_W_END,
		ST_T_WR, ST_T_RD, ST_T_CHK, ST_T_FIN,
		ST_P_CHK, ST_P_RD1, ST_P_RD2, ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic               cell_open;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] goal_x;
		logic [COORD_W-1:0] goal_y;
		logic [LEN_W-1:0]   entry_index;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [LEN_W-1:0]   path_length;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic               moved_horizontally;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} nbr_t;

	function automatic logic [COORD_W:0] step_dx(input logic [1:0] k);
		case (k)
			2'd0:    step_dx = (COORD_W+1)'(1);
			2'd2:    step_dx = '1;
			default: step_dx = '0;
		endcase
	endfunction

	function automatic logic [COORD_W:0] step_dy(input logic [1:0] k);
		case (k)
			2'd1:    step_dy = (COORD_W+1)'(1);
			2'd3:    step_dy = '1;
			default: step_dy = '0;
		endcase
	endfunction

endpackage
`default_nettype wire

[design/lgr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgr_req_if / lgr_rsp_if - valid/ready channels of the maze router
// Command words in, result words out.
// ----------------------------------------------------------------------------
interface lgr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [4:0] cell_x;
	logic [4:0] cell_y;
	logic       cell_open;
	logic [4:0] start_x;
	logic [4:0] start_y;
	logic [4:0] goal_x;
	logic [4:0] goal_y;
	logic [9:0] entry_index;

	modport source (output valid, cmd, cell_x, cell_y, cell_open, start_x, start_y,
		goal_x, goal_y, entry_index, input ready);
	modport sink (input valid, cmd, cell_x, cell_y, cell_open, start_x, start_y,
		goal_x, goal_y, entry_index, output ready);
endinterface

interface lgr_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [9:0] path_length;
	logic [4:0] point_x;
	logic [4:0] point_y;
	logic       moved_horizontally;

	modport source (output valid, status, path_length, point_x, point_y,
		moved_horizontally, input ready);
	modport sink (input valid, status, path_length, point_x, point_y,
		moved_horizontally, output ready);
endinterface
`default_nettype wire

[design/lgr_nbr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgr_nbr - shared neighbour address unit
// Steps one cell in direction k and flags steps that leave the grid.
// ----------------------------------------------------------------------------
module lgr_nbr (
	input  wire logic [lgr_pkg::COORD_W-1:0] x,
	input  wire logic [lgr_pkg::COORD_W-1:0] y,
	input  wire logic [1:0]                  k,
	output lgr_pkg::nbr_t                    nb
);
	import lgr_pkg::*;

	logic [COORD_W:0] sum_x;
	logic [COORD_W:0] sum_y;

	// out-of-range steps below zero wrap to large values and fail the compare
	assign sum_x = {1'b0, x} + step_dx(k);
	assign sum_y = {1'b0, y} + step_dy(k);

	assign nb.valid = (sum_x < (COORD_W+1)'(GRID_WIDTH)) &&
		(sum_y < (COORD_W+1)'(GRID_HEIGHT));
	assign nb.x = sum_x[COORD_W-1:0];
	assign nb.y = sum_y[COORD_W-1:0];

endmodule
`default_nettype wire

[design/lgr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgr_ctrl - router sequencer with cell, wave and path memories
// Wave expansion scan, traceback, cell writes and path reads.
// ----------------------------------------------------------------------------
module lgr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            acc,
	input  wire lgr_pkg::item_t  item,
	output logic                 idle,
	output logic                 res_valid,
	input  wire logic            res_take,
	output lgr_pkg::result_t     res
);
	import lgr_pkg::*;

	ctrl_state_t state_q, state_d;

	item_t              item_q;
	logic [CELL_AW-1:0] c_q;
	logic [1:0]         k_q;
	logic [LEN_W-1:0]   d_q;
	logic               changed_q;
	logic               goal_q;
	logic [COORD_W-1:0] tx_q, ty_q;
	logic [LEN_W-1:0]   td_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   found_q;
	logic               open_s_q;
	logic [1:0]         status_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic               moved_q;

	logic               open_mem [CELL_COUNT];
	logic [WAVE_W-1:0]  wave_mem [CELL_COUNT];
	logic [CELL_AW-1:0] path_mem [MAX_LEN+1];
	logic               open_rd_q;
	logic [WAVE_W-1:0]  wave_rd_q;
	logic [CELL_AW-1:0] path_rd_q;

	logic               open_we, open_wd;
	logic [CELL_AW-1:0] open_wa, open_ra;
	logic               wave_we;
	logic [WAVE_W-1:0]  wave_wd;
	logic [CELL_AW-1:0] wave_wa, wave_ra;
	logic               path_we;
	logic [CELL_AW-1:0] path_wd;
	logic [LEN_W-1:0]   path_wa, path_ra;

	logic               trace;
	nbr_t               nb;
	logic [CELL_AW-1:0] nb_idx, s_idx, g_idx;
	logic               c_last, k_last, wave_hit, nb_free;

	assign trace  = (state_q == ST_T_RD) || (state_q == ST_T_CHK);
	assign s_idx  = {item_q.start_y, item_q.start_x};
	assign g_idx  = {item_q.goal_y, item_q.goal_x};
	assign nb_idx = {nb.y, nb.x};
	assign c_last = (c_q == CELL_AW'(CELL_COUNT - 1));
	assign k_last = (k_q == DIR_LAST);
	// scan compares against wave d, traceback against the decremented step
	assign wave_hit = trace ? (wave_rd_q == {1'b0, td_q}) : (wave_rd_q == {1'b0, d_q});
	assign nb_free  = open_rd_q && (wave_rd_q == UNNUMBERED);

	lgr_nbr u_nbr (
		.x  (trace ? tx_q : c_q[COORD_W-1:0]),
		.y  (trace ? ty_q : c_q[CELL_AW-1:COORD_W]),
		.k  (k_q),
		.nb (nb)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (c_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (acc) begin
					unique case (item.cmd)
						CMD_WRITE: state_d = ST_WCELL;
						CMD_ROUTE: state_d = ST_R_OPS;
						CMD_READ:  state_d = ST_P_CHK;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_WCELL: state_d = ST_DONE;
			ST_R_OPS: state_d = ST_R_OPG;
			ST_R_OPG: state_d = ST_R_OPV;
			ST_R_OPV: begin
				if (!open_s_q || !open_rd_q) state_d = ST_DONE;
				else if (s_idx == g_idx)     state_d = ST_T_FIN;
				else                         state_d = ST_R_INIT;
			end
			ST_R_INIT: if (c_last) state_d = ST_R_SEED;
			ST_R_SEED: state_d = ST_W_RD;
			ST_W_RD:   state_d = ST_W_CHK;
			ST_W_CHK: begin
				if (wave_hit)    state_d = ST_N_RD;
				else if (c_last) state_d = ST_W_END;
				else             state_d = ST_W_RD;
			end
			ST_N_RD: begin
				if (nb.valid)    state_d = ST_N_CHK;
				else if (!k_last) state_d = ST_N_RD;
				else if (c_last) state_d = ST_W_END;
				else             state_d = ST_W_RD;
			end
			ST_N_CHK: begin
				if (!k_last)     state_d = ST_N_RD;
				else if (c_last) state_d = ST_W_END;
				else             state_d = ST_W_RD;
			end
			ST_W_END: begin
				if (goal_q)                                   state_d = ST_T_WR;
				else if (!changed_q || d_q == LEN_W'(MAX_LEN - 1)) state_d = ST_DONE;
				else                                          state_d = ST_W_RD;
			end
			ST_T_WR:  state_d = (td_q == '0) ? ST_T_FIN : ST_T_RD;
			ST_T_RD: begin
				if (nb.valid)    state_d = ST_T_CHK;
				else if (k_last) state_d = ST_T_WR;
			end
			ST_T_CHK: begin
				if (wave_hit || k_last) state_d = ST_T_WR;
				else                    state_d = ST_T_RD;
			end
			ST_T_FIN: state_d = ST_DONE;
			ST_P_CHK: state_d = (item_q.entry_index > found_q) ? ST_DONE : ST_P_RD1;
			ST_P_RD1: state_d = (item_q.entry_index == '0) ? ST_DONE : ST_P_RD2;
			ST_P_RD2: state_d = ST_DONE;
			ST_DONE:  if (res_take) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// memory port controls
	always_comb begin
		open_we = 1'b0;
		open_wa = c_q;
		open_wd = 1'b0;
		open_ra = nb_idx;
		wave_we = 1'b0;
		wave_wa = nb_idx;
		wave_wd = {1'b0, d_q} + WAVE_W'(1);
		wave_ra = nb_idx;
		path_we = 1'b0;
		path_wa = td_q;
		path_wd = {ty_q, tx_q};
		path_ra = item_q.entry_index - LEN_W'(1);
		unique case (state_q)
			ST_CLEAR: open_we = 1'b1;
			ST_WCELL: begin
				open_we = 1'b1;
				open_wa = {item_q.cell_y, item_q.cell_x};
				open_wd = item_q.cell_open;
			end
			ST_R_OPS: open_ra = s_idx;
			ST_R_OPG: open_ra = g_idx;
			ST_R_INIT: begin
				wave_we = 1'b1;
				wave_wa = c_q;
				wave_wd = UNNUMBERED;
			end
			ST_R_SEED: begin
				wave_we = 1'b1;
				wave_wa = s_idx;
				wave_wd = '0;
			end
			ST_W_RD:  wave_ra = c_q;
			ST_N_CHK: wave_we = nb_free;
			ST_T_WR:  path_we = (td_q != '0);
			ST_T_FIN: begin
				path_we = 1'b1;
				path_wa = '0;
				path_wd = s_idx;
			end
			ST_P_CHK: path_ra = item_q.entry_index;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (open_we) open_mem[open_wa] <= open_wd;
		open_rd_q <= open_mem[open_ra];
		if (wave_we) wave_mem[wave_wa] <= wave_wd;
		wave_rd_q <= wave_mem[wave_ra];
		if (path_we) path_mem[path_wa] <= path_wd;
		path_rd_q <= path_mem[path_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			c_q     <= '0;
			found_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR, ST_R_INIT: c_q <= c_q + CELL_AW'(1);
				ST_W_CHK: if (!wave_hit) c_q <= c_q + CELL_AW'(1);
				ST_N_RD:  if (!nb.valid && k_last) c_q <= c_q + CELL_AW'(1);
				ST_N_CHK: if (k_last) c_q <= c_q + CELL_AW'(1);
				ST_T_FIN: found_q <= len_q;
				default: ;
			endcase
		end
	end

	// payload and loop registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					item_q   <= item;
					status_q <= STS_OK;
					px_q     <= '0;
					py_q     <= '0;
					moved_q  <= 1'b0;
				end
			end
			ST_R_OPG: open_s_q <= open_rd_q;
			ST_R_OPV: begin
				len_q <= '0;
				if (!open_s_q || !open_rd_q) status_q <= STS_WALL;
			end
			ST_R_SEED: begin
				d_q       <= '0;
				changed_q <= 1'b0;
				goal_q    <= 1'b0;
			end
			ST_W_CHK: k_q <= '0;
			ST_N_RD:  if (!nb.valid) k_q <= k_q + 2'd1;
			ST_N_CHK: begin
				k_q <= k_q + 2'd1;
				if (nb_free) begin
					changed_q <= 1'b1;
					if (nb_idx == g_idx) goal_q <= 1'b1;
				end
			end
			ST_W_END: begin
				if (goal_q) begin
					len_q <= d_q + LEN_W'(1);
					td_q  <= d_q + LEN_W'(1);
					tx_q  <= item_q.goal_x;
					ty_q  <= item_q.goal_y;
				end else if (!changed_q || d_q == LEN_W'(MAX_LEN - 1)) begin
					status_q <= STS_NOPATH;
				end else begin
					d_q       <= d_q + LEN_W'(1);
					changed_q <= 1'b0;
				end
			end
			ST_T_WR: begin
				k_q <= '0;
				if (td_q != '0) td_q <= td_q - LEN_W'(1);
			end
			ST_T_RD: if (!nb.valid) k_q <= k_q + 2'd1;
			ST_T_CHK: begin
				if (wave_hit) begin
					tx_q <= nb.x;
					ty_q <= nb.y;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			ST_P_CHK: if (item_q.entry_index > found_q) status_q <= STS_IDXBAD;
			ST_P_RD1: begin
				px_q <= path_rd_q[COORD_W-1:0];
				py_q <= path_rd_q[CELL_AW-1:COORD_W];
			end
			ST_P_RD2: moved_q <= (path_rd_q[COORD_W-1:0] != px_q);
			default: ;
		endcase
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res.status             = status_q;
	assign res.path_length        = found_q;
	assign res.point_x            = px_q;
	assign res.point_y            = py_q;
	assign res.moved_horizontally = moved_q;

`ifndef SYNTH
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (state_q == ST_IDLE))
		else $error("word accepted while sequencer busy");
	a_wave_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_W_RD) |-> (d_q < LEN_W'(MAX_LEN)))
		else $error("wave number past limit");
	a_trace_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_T_WR && td_q != '0) |=> (td_q == $past(td_q) - LEN_W'(1)))
		else $error("traceback step count slipped");
	a_hold_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_T_FIN) |=> $stable(found_q))
		else $error("path length changed outside route finish");
`endif

endmodule
`default_nettype wire

[design/lee_grid_maze_router.sv]
`default_nettype none
// Route: endpoint checks, wave-map init over every cell and a seed of the start cell, then per
//   wave a scan of each cell and a look at each neighbour of each front cell, and a wave end;
//   traceback takes one path step at a time, plus a finish step writing the start cell.
// One word in flight; a finished result waits in the output register.
// Reset: after arst_n the cell map clears to walls, not ready.
// ----------------------------------------------------------------------------
// lee_grid_maze_router - Lee maze router on a 32x32 grid
// Breadth-first wave numbering, traceback and stored path lookup.
// ----------------------------------------------------------------------------
module lee_grid_maze_router (
	input  wire logic clk,
	input  wire logic arst_n,
	lgr_req_if.sink   req,
	lgr_rsp_if.source rsp
);
	import lgr_pkg::*;

	item_t   item;
	result_t res, out_q;
	logic    idle, acc, res_valid, res_take, out_valid_q;

	// pack the command word
	assign item.cmd         = req.cmd;
	assign item.cell_x      = req.cell_x;
	assign item.cell_y      = req.cell_y;
	assign item.cell_open   = req.cell_open;
	assign item.start_x     = req.start_x;
	assign item.start_y     = req.start_y;
	assign item.goal_x      = req.goal_x;
	assign item.goal_y      = req.goal_y;
	assign item.entry_index = req.entry_index;

	assign req.ready = idle;
	assign acc       = req.valid && idle;

	// result moves into the output register once it is empty or draining
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	lgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.item      (item),
		.idle      (idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = out_q.status;
	assign rsp.path_length        = out_q.path_length;
	assign rsp.point_x            = out_q.point_x;
	assign rsp.point_y            = out_q.point_y;
	assign rsp.moved_horizontally = out_q.moved_horizontally;

endmodule
`default_nettype wire
